FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the allocator RTL.
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define FFRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true out of reset
`define FFRA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/ffra_pkg.sv
// ---------------------------------------------------------------------------
// ffra_pkg
// Types and fixed constants of the first-fit region allocator.
// ---------------------------------------------------------------------------
package ffra_pkg;

  // Field widths
  localparam int MODE_W = 2;
  localparam int REQ_W  = 16;
  localparam int OFS_W  = 12;
  localparam int SIZE_W = 13;
  localparam int STAT_W = 2;

  // Granule geometry
  localparam int GRAN_BYTES = 8;
  localparam int GRAN_SHIFT = 3;

  // Region size after reset
  localparam logic [SIZE_W-1:0] REGION_RESET = 13'd4096;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // Request word
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFS_W-1:0]  block_offset;
  } req_t;

  // Result word
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFS_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } res_t;

endpackage

FILE: rtl/ffra_ram.sv
// ---------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ffra_engine.sv
// ---------------------------------------------------------------------------
// ffra_engine
// Allocator sequencer: free-map clearing pass, space checks, table slot
// search, one-granule-per-cycle first-fit scan, table lookup and run marking.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ffra_engine import ffra_pkg::*; #(
  parameter int MAX_GRAN = 512,
  parameter int MAX_BLK  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] region_bytes,
  input  logic              req_valid,
  input  req_t              req,
  output logic              req_ready,
  output logic              res_valid,
  output res_t              res,
  input  logic              res_take
);

  // Derived widths
  localparam int GA   = (MAX_GRAN > 1) ? $clog2(MAX_GRAN) : 1;  // granule address
  localparam int CW   = $clog2(MAX_GRAN + 1);                   // granule count
  localparam int BA   = (MAX_BLK > 1) ? $clog2(MAX_BLK) : 1;    // table index
  localparam int BC   = $clog2(MAX_BLK + 1);                    // table count
  localparam int OGW  = OFS_W - GRAN_SHIFT;                     // offset in granules
  localparam int CMPW = (GA > OGW) ? GA : OGW;
  localparam int NGW  = 14;                                     // rounded request
  localparam int NDW  = 17;                                     // request bytes, rounded
  localparam int TW   = GA + CW;                                // table entry

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SLOT  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FIND  = 3'd5;
  localparam logic [2:0] S_MARK  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]         state_r,   state_nxt;
  logic [MODE_W-1:0]  mode_r,    mode_nxt;
  logic [NGW-1:0]     ngran_r,   ngran_nxt;
  logic [NDW-1:0]     need_r,    need_nxt;
  logic [OGW-1:0]     og_r,      og_nxt;
  logic [CW-1:0]      tg_r,      tg_nxt;
  logic [SIZE_W-1:0]  used_r,    used_nxt;
  logic [MAX_BLK-1:0] valid_r,   valid_nxt;
  logic [BA-1:0]      slot_r,    slot_nxt;
  logic [BC-1:0]      sl_r,      sl_nxt;
  logic [CW-1:0]      sc_rd_r,   sc_rd_nxt;
  logic               sc_pend_r, sc_pend_nxt;
  logic [GA-1:0]      sc_chk_r,  sc_chk_nxt;
  logic [CW-1:0]      run_r,     run_nxt;
  logic [GA-1:0]      rstart_r,  rstart_nxt;
  logic [BC-1:0]      fd_rd_r,   fd_rd_nxt;
  logic               fd_pend_r, fd_pend_nxt;
  logic [BA-1:0]      fd_chk_r,  fd_chk_nxt;
  logic [GA-1:0]      mk_g_r,    mk_g_nxt;
  logic [CW-1:0]      mk_n_r,    mk_n_nxt;
  logic               mk_val_r,  mk_val_nxt;
  res_t               res_r,     res_nxt;

  // Memory ports
  logic          map_we;
  logic [0:0]    map_rdata;
  logic          tbl_we;
  logic [TW-1:0] tbl_wdata;
  logic [TW-1:0] tbl_rdata;
  logic [GA-1:0] tbl_start;
  logic [CW-1:0] tbl_cnt;
  logic [GA-1:0] scan_start;

  // Request decode helpers
  logic [NDW-1:0] req_round;
  logic [NGW-1:0] region_g;
  logic [NDW-1:0] total_b;
  logic [NDW-1:0] used_b;
  logic [15:0]    blk_bytes;
  logic           sc_issue;
  logic           fd_issue;
  logic           fd_hit;

  assign req_round = NDW'(req.request_bytes) + NDW'(GRAN_BYTES - 1);
  assign region_g  = NGW'((NGW'(region_bytes) + NGW'(GRAN_BYTES - 1)) >> GRAN_SHIFT);
  assign total_b   = NDW'({tg_r, {GRAN_SHIFT{1'b0}}});
  assign used_b    = NDW'(used_r);
  assign tbl_start = tbl_rdata[TW-1:CW];
  assign tbl_cnt   = tbl_rdata[CW-1:0];
  assign blk_bytes = 16'({tbl_cnt, {GRAN_SHIFT{1'b0}}});
  assign scan_start = (run_r == '0) ? sc_chk_r : rstart_r;

  // Read issue and hit detection for the two walks
  assign sc_issue = (sc_rd_r < tg_r);
  assign fd_issue = (fd_rd_r < BC'(MAX_BLK));
  assign fd_hit   = fd_pend_r && valid_r[fd_chk_r] &&
                    (CMPW'(tbl_start) == CMPW'(og_r));

  assign map_we    = (state_r == S_CLEAR) || (state_r == S_MARK);
  assign tbl_wdata = {scan_start, CW'(ngran_r)};

  // Granule free map, one bit per granule
  ffra_ram #(
    .WIDTH (1),
    .DEPTH (MAX_GRAN)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (mk_g_r),
    .wdata (mk_val_r),
    .raddr (GA'(sc_rd_r)),
    .rdata (map_rdata)
  );

  // Block table: start granule and granule count
  ffra_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_BLK)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (slot_r),
    .wdata (tbl_wdata),
    .raddr (BA'(fd_rd_r)),
    .rdata (tbl_rdata)
  );

  // Next-state logic
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    ngran_nxt   = ngran_r;
    need_nxt    = need_r;
    og_nxt      = og_r;
    tg_nxt      = tg_r;
    used_nxt    = used_r;
    valid_nxt   = valid_r;
    slot_nxt    = slot_r;
    sl_nxt      = sl_r;
    sc_rd_nxt   = sc_rd_r;
    sc_pend_nxt = sc_pend_r;
    sc_chk_nxt  = sc_chk_r;
    run_nxt     = run_r;
    rstart_nxt  = rstart_r;
    fd_rd_nxt   = fd_rd_r;
    fd_pend_nxt = fd_pend_r;
    fd_chk_nxt  = fd_chk_r;
    mk_g_nxt    = mk_g_r;
    mk_n_nxt    = mk_n_r;
    mk_val_nxt  = mk_val_r;
    res_nxt     = res_r;
    tbl_we      = 1'b0;

    unique case (state_r)
      // Sweep the free map to all free after reset
      S_CLEAR: begin
        mk_g_nxt = mk_g_r + 1'b1;
        mk_n_nxt = mk_n_r - 1'b1;
        if (mk_n_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Latch and decode a new request
      S_IDLE: begin
        if (req_valid) begin
          mode_nxt  = req.mode;
          ngran_nxt = NGW'(req_round >> GRAN_SHIFT);
          need_nxt  = req_round & ~NDW'(GRAN_BYTES - 1);
          og_nxt    = req.block_offset[OFS_W-1:GRAN_SHIFT];
          tg_nxt    = (region_g > NGW'(MAX_GRAN)) ? CW'(MAX_GRAN) : CW'(region_g);
          res_nxt   = '0;
          fd_rd_nxt   = '0;
          fd_pend_nxt = 1'b0;
          case (req.mode) inside
            MODE_ALLOC: state_nxt = S_CHECK;
            MODE_FREE, MODE_QUERY: begin
              if (req.block_offset[GRAN_SHIFT-1:0] != '0) begin
                res_nxt.status = ST_NOTFOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_FIND;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Size and free space checks
      S_CHECK: begin
        if ((ngran_r == '0) || (used_b >= total_b) || (need_r > total_b - used_b)) begin
          res_nxt.status = ST_NOSPACE;
          state_nxt      = S_DONE;
        end else begin
          sl_nxt    = '0;
          state_nxt = S_SLOT;
        end
      end

      // First unused table entry, one per cycle
      S_SLOT: begin
        if (sl_r == BC'(MAX_BLK)) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_DONE;
        end else if (!valid_r[BA'(sl_r)]) begin
          slot_nxt    = BA'(sl_r);
          sc_rd_nxt   = '0;
          sc_pend_nxt = 1'b0;
          run_nxt     = '0;
          state_nxt   = S_SCAN;
        end else begin
          sl_nxt = sl_r + 1'b1;
        end
      end

      // First-fit walk, one granule per cycle behind the read latency
      S_SCAN: begin
        sc_pend_nxt = sc_issue;
        sc_chk_nxt  = GA'(sc_rd_r);
        if (sc_issue) begin
          sc_rd_nxt = sc_rd_r + 1'b1;
        end
        if (sc_pend_r && map_rdata[0]) begin
          run_nxt = run_r + 1'b1;
          if (run_r == '0) begin
            rstart_nxt = sc_chk_r;
          end
          if ((NGW'(run_r) + NGW'(1)) == ngran_r) begin
            // Run long enough: claim it
            tbl_we           = 1'b1;
            valid_nxt[slot_r] = 1'b1;
            used_nxt         = SIZE_W'(used_b + need_r);
            mk_g_nxt         = scan_start;
            mk_n_nxt         = CW'(ngran_r);
            mk_val_nxt       = 1'b0;
            res_nxt.status   = ST_OK;
            res_nxt.offset   = OFS_W'({scan_start, {GRAN_SHIFT{1'b0}}});
            res_nxt.size     = SIZE_W'(need_r);
            state_nxt        = S_MARK;
          end
        end else if (sc_pend_r) begin
          run_nxt = '0;
        end else if (!sc_issue) begin
          res_nxt.status = ST_NOSPACE;
          state_nxt      = S_DONE;
        end
      end

      // Table lookup by start granule, one entry per cycle
      S_FIND: begin
        fd_pend_nxt = fd_issue;
        fd_chk_nxt  = BA'(fd_rd_r);
        if (fd_issue) begin
          fd_rd_nxt = fd_rd_r + 1'b1;
        end
        if (fd_hit) begin
          res_nxt.status = ST_OK;
          if (mode_r == MODE_FREE) begin
            valid_nxt[fd_chk_r] = 1'b0;
            used_nxt   = (16'(used_r) >= blk_bytes) ?
                         SIZE_W'(16'(used_r) - blk_bytes) : '0;
            mk_g_nxt   = tbl_start;
            mk_n_nxt   = tbl_cnt;
            mk_val_nxt = 1'b1;
            state_nxt  = S_MARK;
          end else begin
            res_nxt.size = SIZE_W'(blk_bytes);
            state_nxt    = S_DONE;
          end
        end else if (!fd_pend_r && !fd_issue) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end
      end

      // Write a run of granules used or free
      S_MARK: begin
        mk_g_nxt = mk_g_r + 1'b1;
        mk_n_nxt = mk_n_r - 1'b1;
        if (mk_n_r == CW'(1)) begin
          state_nxt = S_DONE;
        end
      end

      // Hold the result until taken
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      used_r    <= '0;
      valid_r   <= '0;
      mk_g_r    <= '0;
      mk_n_r    <= CW'(MAX_GRAN);
      mk_val_r  <= 1'b1;
      sc_pend_r <= 1'b0;
      fd_pend_r <= 1'b0;
      run_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      valid_r   <= valid_nxt;
      mk_g_r    <= mk_g_nxt;
      mk_n_r    <= mk_n_nxt;
      mk_val_r  <= mk_val_nxt;
      sc_pend_r <= sc_pend_nxt;
      fd_pend_r <= fd_pend_nxt;
      run_r     <= run_nxt;
    end
  end

  // Request and working registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    ngran_r  <= ngran_nxt;
    need_r   <= need_nxt;
    og_r     <= og_nxt;
    tg_r     <= tg_nxt;
    slot_r   <= slot_nxt;
    sl_r     <= sl_nxt;
    sc_rd_r  <= sc_rd_nxt;
    sc_chk_r <= sc_chk_nxt;
    rstart_r <= rstart_nxt;
    fd_rd_r  <= fd_rd_nxt;
    fd_chk_r <= fd_chk_nxt;
    res_r    <= res_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Checks
  `FFRA_NEVER(a_used_aligned, used_r[GRAN_SHIFT-1:0] != '0, "used bytes not granule aligned")
  `FFRA_ASSERT(a_run_bound, (state_r == S_SCAN) |-> (NGW'(run_r) < ngran_r), "run overran request")
  `FFRA_ASSERT(a_mark_count, (state_r == S_MARK || state_r == S_CLEAR) |-> (mk_n_r != '0), "empty run write")
  `FFRA_ASSERT(a_fail_zero, (state_r == S_DONE && res_r.status != ST_OK) |-> (res_r.size == '0 && res_r.offset == '0), "failed result carries data")
  `FFRA_ASSERT(a_start_busy, (req_valid && state_r == S_IDLE) |=> (state_r != S_IDLE), "request not started")

endmodule

FILE: rtl/first_fit_region_allocator_top.sv
// ---------------------------------------------------------------------------
// first_fit_region_allocator_top
// First-fit allocator over one region of 8-byte granules, with a block table.
// ---------------------------------------------------------------------------
// Usage: after reset the block walks the whole free map once to mark every
// granule free; in_stall stays high meanwhile. Then it takes one request
// word at a time. An allocate checks free space, finds the first free table
// slot, scans the free map one granule per cycle through the map RAM's
// single read port, and marks the granules it claims. A free searches the
// table and then releases its granules one per cycle; a query searches the
// table only. A finished result sits in an output register, so the next
// request is taken while it waits to be read.
// Write cfg_region_bytes only while no request is in progress.
// ---------------------------------------------------------------------------
module first_fit_region_allocator_top import ffra_pkg::*; #(
  parameter int MAX_REGION_GRANULES = 512,
  parameter int MAX_BLOCKS          = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [REQ_W-1:0]  in_request_bytes,
  input  logic [OFS_W-1:0]  in_block_offset,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [OFS_W-1:0]  out_offset_out,
  output logic [SIZE_W-1:0] out_size_out,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_region_bytes
);

  logic [SIZE_W-1:0] region_r, region_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  logic  req_ready;
  logic  res_valid;
  logic  res_take;
  req_t  req;
  res_t  res;

  // Request word
  assign req.mode          = in_mode;
  assign req.request_bytes = in_request_bytes;
  assign req.block_offset  = in_block_offset;

  assign in_stall  = !req_ready;
  assign cfg_ready = 1'b1;

  ffra_engine #(
    .MAX_GRAN (MAX_REGION_GRANULES),
    .MAX_BLK  (MAX_BLOCKS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .region_bytes (region_r),
    .req_valid    (in_valid),
    .req          (req),
    .req_ready    (req_ready),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // Output register loads when empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    region_nxt    = cfg_valid ? cfg_region_bytes : region_r;
    out_valid_nxt = res_take ? 1'b1 : (out_valid_r && out_stall);
    out_res_nxt   = res_take ? res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r    <= REGION_RESET;
      out_valid_r <= 1'b0;
    end else begin
      region_r    <= region_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_offset_out = out_res_r.offset;
  assign out_size_out   = out_res_r.size;

endmodule
